>>> src/bfcw_pkg.sv
// Shared types and constants for the frame to video memory write converter.
`timescale 1ns / 1ps
package bfcw_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [13:0] OFFSET_MASK = 14'h3fff;
    localparam logic [14:0] HALF_STRIDE = 15'd4096;
    localparam logic [14:0] ROW_STRIDE  = 15'd40;
    localparam logic [15:0] BLACK_WORD  = 16'h0000;
    localparam logic [15:0] WHITE_WORD  = 16'hffff;
    localparam logic [2:0]  LAST_ROW    = 3'd7;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_end;
    } bfcw_in_t;

    typedef struct packed {
        logic [14:0] word_address;
        logic [15:0] word_value;
        logic        last_of_record;
    } bfcw_out_t;

    // one parsed record command: a whole fill, or a single data row
    typedef struct packed {
        logic        is_fill;
        logic [2:0]  row;
        logic [13:0] offset;
        logic [15:0] value;
    } bfcw_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bfcw_qstat_t;

endpackage

>>> src/bfcw_parser.sv
// Front end: accepts frame bytes, tracks record phase and emits write commands.
`timescale 1ns / 1ps
module bfcw_parser
    import bfcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bfcw_in_t    s_data,
    input  bfcw_qstat_t q_stat,
    output logic        q_push,
    output bfcw_cmd_t   q_cmd
);

    typedef enum logic [1:0] {
        PH_MARK_LO,
        PH_MARK_HI,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  mark_lo_reg, mark_lo_next;
    logic [13:0] offset_reg, offset_next;
    logic [2:0]  row_reg, row_next;
    logic [15:0] mark;
    logic        accept;
    logic        gen;

    // 1 bpp to 2 bpp, then swap the two bytes
    function automatic logic [15:0] expand_byte(input logic [7:0] b);
        logic [15:0] r;
        for (int i = 0; i < 8; i++) begin
            r[2*i]   = b[i];
            r[2*i+1] = b[i];
        end
        return {r[7:0], r[15:8]};
    endfunction

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign mark    = {s_data.byte_value, mark_lo_reg};
    assign q_push  = accept && gen;

    always_comb begin
        phase_next  = phase_reg;
        mark_lo_next = mark_lo_reg;
        offset_next = offset_reg;
        row_next    = row_reg;
        gen         = 1'b0;
        q_cmd.is_fill = 1'b0;
        q_cmd.row     = row_reg;
        q_cmd.offset  = offset_reg;
        q_cmd.value   = expand_byte(s_data.byte_value);
        unique case (phase_reg)
            PH_MARK_LO: begin
                mark_lo_next = s_data.byte_value;
                phase_next   = PH_MARK_HI;
            end
            PH_MARK_HI: begin
                if (mark[15:14] != 2'b00) begin
                    gen           = 1'b1;
                    q_cmd.is_fill = 1'b1;
                    q_cmd.row     = 3'd0;
                    q_cmd.offset  = mark[13:0] & OFFSET_MASK;
                    // black wins over white
                    q_cmd.value   = mark[14] ? BLACK_WORD : WHITE_WORD;
                    phase_next    = PH_MARK_LO;
                end else begin
                    offset_next = mark[13:0] & OFFSET_MASK;
                    row_next    = 3'd0;
                    phase_next  = PH_DATA;
                end
            end
            PH_DATA: begin
                gen        = 1'b1;
                row_next   = row_reg + 3'd1;
                phase_next = (row_reg == LAST_ROW) ? PH_MARK_LO : PH_DATA;
            end
            default: phase_next = PH_MARK_LO;
        endcase
        if (s_data.frame_end) begin
            phase_next = PH_MARK_LO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MARK_LO;
            mark_lo_reg <= 8'd0;
            offset_reg  <= 14'd0;
            row_reg     <= 3'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            mark_lo_reg <= mark_lo_next;
            offset_reg  <= offset_next;
            row_reg     <= row_next;
        end
    end

endmodule

>>> src/bfcw_queue.sv
// Small command queue between parser and writer.
`timescale 1ns / 1ps
module bfcw_queue
    import bfcw_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bfcw_cmd_t   push_cmd,
    input  logic        pop,
    output bfcw_cmd_t   head_cmd,
    output bfcw_qstat_t stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bfcw_cmd_t     slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> src/bfcw_writer.sv
// Back end: turns queued commands into word writes behind an output register.
`timescale 1ns / 1ps
module bfcw_writer
    import bfcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bfcw_qstat_t q_stat,
    input  bfcw_cmd_t   head_cmd,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output bfcw_out_t   m_data
);

    logic        m_valid_reg;
    bfcw_out_t   m_data_reg, m_data_next;
    logic [2:0]  fill_row_reg;
    logic [2:0]  row;
    logic        can_load;
    logic        emit;

    function automatic logic [14:0] row_offset(input logic [1:0] r);
        logic [14:0] v;
        case (r)
            2'd0:    v = 15'd0;
            2'd1:    v = ROW_STRIDE;
            2'd2:    v = ROW_STRIDE + ROW_STRIDE;
            default: v = ROW_STRIDE + ROW_STRIDE + ROW_STRIDE;
        endcase
        return v;
    endfunction

    assign can_load = !m_valid_reg || m_ready;
    assign emit     = can_load && !q_stat.empty;
    assign row      = head_cmd.is_fill ? fill_row_reg : head_cmd.row;
    // a fill stays at the head until its eighth row goes out
    assign q_pop    = emit && (!head_cmd.is_fill || fill_row_reg == LAST_ROW);

    always_comb begin
        m_data_next.word_address = {1'b0, head_cmd.offset}
                                 + (row[2] ? HALF_STRIDE : 15'd0)
                                 + row_offset(row[1:0]);
        m_data_next.word_value     = head_cmd.value;
        m_data_next.last_of_record = (row == LAST_ROW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            fill_row_reg <= 3'd0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
                if (head_cmd.is_fill) begin
                    fill_row_reg <= fill_row_reg + 3'd1;
                end
            end else if (can_load) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/block_frame_to_cga_writes_unit.sv
// Top level of the frame record to video memory word write converter.
//
// s_valid/s_ready/s_data carry one frame byte per item, with a frame_end flag
// that sends the parser back to the start of a record mark.
// m_valid/m_ready/m_data carry one video memory word write per item.
// A data byte gives one write: it is pushed into the command queue, then
// moved from the queue head into the output register that drives m_data.
// A black or white mark gives eight writes, one per row, which the writer
// produces from a single queue entry through the same output register.
// Input is taken once per cycle while the command queue (QUEUE_DEPTH
// entries) has room; throughput on the write side is one write per cycle
// while m_ready is high, set by the single output register of the writer.
// A fill holds the queue head until its eight writes have gone out, so a
// byte stream after a fill backs up into the queue and then stalls s_ready.
// When m_ready is low the output register holds its write, the queue fills,
// and s_ready drops once the queue is full; nothing is lost.
// aresetn is synchronous, active low: the parser returns to the mark low
// byte, the queue empties and m_valid drops.
`timescale 1ns / 1ps
module block_frame_to_cga_writes_unit
    import bfcw_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bfcw_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bfcw_out_t m_data
);

    bfcw_qstat_t q_stat;
    bfcw_cmd_t   push_cmd;
    bfcw_cmd_t   head_cmd;
    logic        q_push;
    logic        q_pop;

    bfcw_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    bfcw_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    bfcw_writer u_writer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_cmd (head_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.word_address <= 15'd20599))
        else $error("write address out of range");

    a_fill_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && head_cmd.is_fill) |=>
            (m_data.last_of_record && (m_data.word_value == BLACK_WORD
                                       || m_data.word_value == WHITE_WORD)))
        else $error("fill record did not end on a black or white last write");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the frame record to video memory write converter.
`timescale 1ns / 1ps
module tb_top
    import bfcw_pkg::*;
();

    localparam logic [3:0] PH_MARK_LO = 4'd0;
    localparam logic [3:0] PH_MARK_HI = 4'd1;
    localparam logic [3:0] PH_DATA_0  = 4'd2;
    localparam logic [3:0] PH_DATA_7  = 4'd9;

    localparam int FILL_BLACK = 0;
    localparam int FILL_WHITE = 1;
    localparam int FILL_BOTH  = 2;
    localparam int NO_CUT     = -1;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_TAIL   = 24;

    // Tracks the parser and holds the writes still owed by the block.
    class cga_write_tracker;
        logic [3:0]  phase;
        logic [7:0]  mark_lo;
        logic [13:0] rec_offset;
        bfcw_out_t   pending_writes[$];
        int          mismatches;
        int          writes_checked;

        function new();
            phase          = PH_MARK_LO;
            mark_lo        = '0;
            rec_offset     = '0;
            mismatches     = 0;
            writes_checked = 0;
        endfunction

        // 1bpp -> 2bpp, then swap the two bytes
        function logic [15:0] pixel_word(logic [7:0] b);
            logic [15:0] r;
            r = '0;
            for (int i = 0; i < 8; i++)
                if (b[i]) r[2*i +: 2] = 2'b11;
            return {r[7:0], r[15:8]};
        endfunction

        function logic [14:0] row_address(logic [13:0] off, logic [2:0] k);
            return {1'b0, off} + (k[2] ? HALF_STRIDE : 15'd0) + 15'(k[1:0]) * ROW_STRIDE;
        endfunction

        function void note_byte(bfcw_in_t item);
            logic [15:0] mark;
            logic [2:0]  k;
            bfcw_out_t   w;
            if (phase == PH_MARK_HI) begin
                mark = {item.byte_value, mark_lo};
                if (mark[15] || mark[14]) begin
                    // black wins over white
                    for (int r = 0; r < 8; r++) begin
                        w.word_address   = row_address(mark[13:0], 3'(r));
                        w.word_value     = mark[14] ? BLACK_WORD : WHITE_WORD;
                        w.last_of_record = (3'(r) == LAST_ROW);
                        pending_writes.push_back(w);
                    end
                    phase = PH_MARK_LO;
                end else begin
                    rec_offset = mark[13:0] & OFFSET_MASK;
                    phase      = PH_DATA_0;
                end
            end else if (phase >= PH_DATA_0 && phase <= PH_DATA_7) begin
                k                = 3'(phase - PH_DATA_0);
                w.word_address   = row_address(rec_offset, k);
                w.word_value     = pixel_word(item.byte_value);
                w.last_of_record = (k == LAST_ROW);
                pending_writes.push_back(w);
                phase = (k == LAST_ROW) ? PH_MARK_LO : phase + 4'd1;
            end else begin
                mark_lo = item.byte_value;
                phase   = PH_MARK_HI;
            end
            if (item.frame_end) phase = PH_MARK_LO;
        endfunction

        function void check_write(bfcw_out_t got);
            bfcw_out_t want;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write addr=%h value=%h last=%b", $realtime,
                         got.word_address, got.word_value, got.last_of_record);
                mismatches++;
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (got.word_address !== want.word_address) begin
                $display("%0t: word_address expected %h got %h", $realtime,
                         want.word_address, got.word_address);
                mismatches++;
            end
            if (got.word_value !== want.word_value) begin
                $display("%0t: word_value expected %h got %h", $realtime,
                         want.word_value, got.word_value);
                mismatches++;
            end
            if (got.last_of_record !== want.last_of_record) begin
                $display("%0t: last_of_record expected %b got %b", $realtime,
                         want.last_of_record, got.last_of_record);
                mismatches++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bfcw_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bfcw_out_t m_data;

    cga_write_tracker board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int frame_ends = 0;
    int fill_records = 0;
    int data_records = 0;

    block_frame_to_cga_writes_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_byte(s_data);
            if (m_valid && m_ready) board.check_write(m_data);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fe);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{byte_value: b, frame_end: fe};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (fe) frame_ends++;
        @(negedge aclk);
    endtask

    // cut_at: byte index that carries frame_end, NO_CUT for none
    task automatic send_fill(input logic [13:0] off, input int color, input int cut_at);
        logic [15:0] mark;
        mark = {color != FILL_BLACK, color != FILL_WHITE, off};
        fill_records++;
        send_byte(mark[7:0], cut_at == 0);
        if (cut_at != 0) send_byte(mark[15:8], cut_at == 1);
    endtask

    task automatic send_data_record(input logic [13:0] off, input logic [63:0] pixels,
                                    input int cut_at);
        logic [15:0] mark;
        logic [7:0]  b;
        logic        fe;
        mark = {2'b00, off};
        data_records++;
        for (int i = 0; i < 10; i++) begin
            b  = (i == 0) ? mark[7:0] : (i == 1) ? mark[15:8] : pixels[8*(i-2) +: 8];
            fe = (i == cut_at);
            send_byte(b, fe);
            if (fe) break;
        end
    endtask

    function automatic logic [13:0] pick_offset();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 14'd0;
        if (r == 1) return OFFSET_MASK;
        return 14'($urandom_range(16383));
    endfunction

    task automatic random_records(input int until_count);
        int sel;
        int r;
        int cut;
        while (items_sent < until_count) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                r   = $urandom_range(19);
                cut = (r == 0) ? 0 : (r == 1) ? 1 : NO_CUT;
                send_fill(pick_offset(), $urandom_range(FILL_BOTH), cut);
            end else if (sel < 88) begin
                cut = ($urandom_range(9) == 0) ? $urandom_range(9) : NO_CUT;
                send_data_record(pick_offset(), {$urandom, $urandom}, cut);
            end else begin
                // stray byte, then resync on a flagged byte
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    initial begin
        int base;
        board = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 48;
        send_fill(14'd0, FILL_BLACK, NO_CUT);
        send_fill(OFFSET_MASK, FILL_WHITE, NO_CUT);
        send_fill(14'h2aaa, FILL_BOTH, NO_CUT);
        send_data_record(OFFSET_MASK, 64'hf00f_aa55_8001_ff00, NO_CUT);
        send_byte(8'h12, 1'b1);                          // frame ends inside a mark
        send_data_record(14'd0, 64'h0000_0000_0000_7e81, 3); // frame ends inside data
        send_fill(14'h0010, FILL_BLACK, 1);              // frame end on fill high byte

        base = items_sent;
        random_records(base + RANDOM_ITEMS / 3);
        send_idle_pct = 48;
        recv_idle_pct = 20;
        random_records(base + 2 * RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_records(base + RANDOM_ITEMS);
        s_valid <= 1'b0;

        while (board.pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Sent %0d bytes: %0d fill and %0d data records, %0d frame ends",
                 items_sent, fill_records, data_records, frame_ends);
        $display("Checked %0d word writes under three idle mixes, %0d mismatches",
                 board.writes_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_writes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
